### hdl/string_literal_escape_decoder_defines.svh
// Assertion macros for the string literal escape decoder.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef STRING_LITERAL_ESCAPE_DECODER_DEFINES_SVH
`define STRING_LITERAL_ESCAPE_DECODER_DEFINES_SVH

// Property that holds in every cycle outside reset.
`define SLED_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define SLED_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sled_pkg.sv
// Shared types and constants for the string literal escape decoder.
// No dependencies.
package sled_pkg;

  typedef enum logic [9:0] {
    MODE_IDLE      = 10'b00_0000_0001,
    MODE_STR       = 10'b00_0000_0010,
    MODE_ESC       = 10'b00_0000_0100,
    MODE_CODE      = 10'b00_0000_1000,
    MODE_GAP       = 10'b00_0001_0000,
    MODE_GAP_SLASH = 10'b00_0010_0000,
    MODE_LINE      = 10'b00_0100_0000,
    MODE_BLK       = 10'b00_1000_0000,
    MODE_BLK_STAR  = 10'b01_0000_0000,
    MODE_BLK_END   = 10'b10_0000_0000
  } mode_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_EOF     = 3'd1,
    ERR_NEWLINE = 3'd2,
    ERR_ESCAPE  = 3'd3,
    ERR_CODE    = 3'd4
  } err_e;

  typedef struct packed {
    mode_e      mode;
    logic       mask;
    logic [7:0] accum;
    logic       colon;
  } state_t;

  typedef struct packed {
    logic       has;
    logic [7:0] data;
    logic       last;
    logic [1:0] pb;
    err_e       err;
  } res_t;

  localparam state_t ST_RESET = '{mode: MODE_IDLE, mask: 1'b0, accum: 8'd0, colon: 1'b0};

  localparam logic [1:0] PB_ONE = 2'd1;
  localparam logic [1:0] PB_TWO = 2'd2;

  localparam logic [7:0] MASK_BIT  = 8'h80;
  localparam logic [7:0] CODE_MAX  = 8'd255;
  localparam logic [7:0] DIGIT_BASE = 8'd18;

  localparam logic [7:0] CH_EOF    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  localparam logic [7:0] V_NL     = 8'd10;
  localparam logic [7:0] V_LBRACK = 8'd16;
  localparam logic [7:0] V_RBRACK = 8'd17;
  localparam logic [7:0] V_DOT    = 8'd28;
  localparam logic [7:0] V_LT     = 8'd29;
  localparam logic [7:0] V_DASH   = 8'd30;
  localparam logic [7:0] V_GT     = 8'd31;
  localparam logic [7:0] V_LPAREN = 8'd128;
  localparam logic [7:0] V_EQ     = 8'd129;
  localparam logic [7:0] V_RPAREN = 8'd130;

endpackage

### hdl/sled_step.sv
// One decode step: parser state plus one source byte give the next state
// and at most one result transaction. Depends on sled_pkg.
module sled_step import sled_pkg::*; (
  input  state_t     state_i,
  input  logic [7:0] data_i,
  output state_t     state_o,
  output res_t       res_o
);

  logic [7:0]  mask_v;
  logic        is_digit;
  logic [3:0]  digit_v;
  logic [7:0]  digit_sub;
  logic [11:0] code_sum;
  logic        code_ovf;
  state_t      gap_state;
  res_t        gap_res;
  res_t        res_none;

  assign mask_v    = state_i.mask ? MASK_BIT : 8'h00;
  assign is_digit  = (data_i >= CH_0) && (data_i <= CH_9);
  assign digit_sub = data_i - CH_0;
  assign digit_v   = digit_sub[3:0];
  // accum * 10 + digit as shifts and adds
  assign code_sum  = {1'b0, state_i.accum, 3'b000} + {3'b000, state_i.accum, 1'b0}
                   + {8'd0, digit_v};
  assign code_ovf  = code_sum > {4'd0, CODE_MAX};

  assign res_none = '{has: 1'b0, data: 8'd0, last: 1'b0, pb: 2'd0, err: ERR_NONE};

  // Byte between two literals; shared by plain gap and just after a comment.
  always_comb begin
    gap_state = state_i;
    gap_res   = res_none;
    if (data_i == CH_EOF) begin
      gap_state = ST_RESET;
      gap_res   = '{has: 1'b1, data: 8'd0, last: 1'b1, pb: PB_ONE, err: ERR_NONE};
    end else if (data_i <= CH_SPACE) begin
      gap_state.mode = MODE_GAP;
    end else if (data_i == CH_SLASH) begin
      gap_state.mode = MODE_GAP_SLASH;
    end else if (data_i == CH_QUOTE) begin
      gap_state.colon = 1'b0;
      gap_state.mode  = MODE_STR;
    end else if (data_i == CH_COLON && !state_i.colon) begin
      gap_state.colon = 1'b1;
      gap_state.mode  = MODE_GAP;
      gap_res         = '{has: 1'b1, data: 8'd0, last: 1'b0, pb: 2'd0, err: ERR_NONE};
    end else begin
      gap_state = ST_RESET;
      gap_res   = '{has: 1'b1, data: 8'd0, last: 1'b1, pb: PB_ONE, err: ERR_NONE};
    end
  end

  always_comb begin
    state_o = state_i;
    res_o   = res_none;
    unique case (state_i.mode) inside
      MODE_IDLE: begin
        if (data_i == CH_QUOTE) begin
          state_o.mask  = 1'b0;
          state_o.colon = 1'b0;
          state_o.mode  = MODE_STR;
        end
      end
      MODE_STR: begin
        if (data_i == CH_EOF) begin
          state_o = ST_RESET;
          res_o   = '{has: 1'b1, data: 8'd0, last: 1'b1, pb: 2'd0, err: ERR_EOF};
        end else if (data_i == CH_NL) begin
          state_o = ST_RESET;
          res_o   = '{has: 1'b1, data: 8'd0, last: 1'b1, pb: 2'd0, err: ERR_NEWLINE};
        end else if (data_i == CH_BSLASH) begin
          state_o.mode = MODE_ESC;
        end else if (data_i == CH_QUOTE) begin
          state_o.mask = 1'b0;
          state_o.mode = MODE_GAP;
        end else begin
          res_o = '{has: 1'b1, data: data_i | mask_v, last: 1'b0, pb: 2'd0, err: ERR_NONE};
        end
      end
      MODE_ESC: begin
        state_o.mode = MODE_STR;
        res_o.has    = 1'b1;
        if (data_i == CH_EOF) begin
          state_o = ST_RESET;
          res_o   = '{has: 1'b1, data: 8'd0, last: 1'b1, pb: 2'd0, err: ERR_EOF};
        end else if (is_digit) begin
          res_o.data = DIGIT_BASE + {4'd0, digit_v};
        end else begin
          unique case (data_i)
            CH_N:      res_o.data = V_NL;
            CH_QUOTE:  res_o.data = CH_QUOTE | mask_v;
            CH_BSLASH: res_o.data = CH_BSLASH | mask_v;
            CH_B: begin
              state_o.mask = ~state_i.mask;
              res_o.has    = 1'b0;
            end
            CH_LBRACK: res_o.data = V_LBRACK;
            CH_RBRACK: res_o.data = V_RBRACK;
            CH_DOT:    res_o.data = V_DOT | mask_v;
            CH_LT:     res_o.data = V_LT;
            CH_DASH:   res_o.data = V_DASH;
            CH_GT:     res_o.data = V_GT;
            CH_LPAREN: res_o.data = V_LPAREN;
            CH_EQ:     res_o.data = V_EQ;
            CH_RPAREN: res_o.data = V_RPAREN;
            CH_LBRACE: begin
              state_o.accum = 8'd0;
              state_o.mode  = MODE_CODE;
              res_o.has     = 1'b0;
            end
            default: begin
              state_o = ST_RESET;
              res_o   = '{has: 1'b1, data: 8'd0, last: 1'b1, pb: 2'd0, err: ERR_ESCAPE};
            end
          endcase
        end
      end
      MODE_CODE: begin
        if (data_i == CH_RBRACE) begin
          state_o.mode = MODE_STR;
          res_o = '{has: 1'b1, data: state_i.accum, last: 1'b0, pb: 2'd0, err: ERR_NONE};
        end else if (!is_digit || code_ovf) begin
          state_o = ST_RESET;
          res_o   = '{has: 1'b1, data: 8'd0, last: 1'b1, pb: 2'd0, err: ERR_CODE};
        end else begin
          state_o.accum = code_sum[7:0];
        end
      end
      MODE_GAP, MODE_BLK_END: begin
        state_o = gap_state;
        res_o   = gap_res;
      end
      MODE_GAP_SLASH: begin
        if (data_i == CH_SLASH) begin
          state_o.mode = MODE_LINE;
        end else if (data_i == CH_STAR) begin
          state_o.mode = MODE_BLK_STAR;
        end else begin
          state_o = ST_RESET;
          res_o   = '{has: 1'b1, data: 8'd0, last: 1'b1, pb: PB_TWO, err: ERR_NONE};
        end
      end
      MODE_LINE: begin
        if (data_i == CH_EOF) begin
          state_o = ST_RESET;
          res_o   = '{has: 1'b1, data: 8'd0, last: 1'b1, pb: PB_ONE, err: ERR_NONE};
        end else if (data_i == CH_NL) begin
          state_o.mode = MODE_GAP;
        end
      end
      MODE_BLK, MODE_BLK_STAR: begin
        if (data_i == CH_EOF) begin
          state_o = ST_RESET;
          res_o   = '{has: 1'b1, data: 8'd0, last: 1'b1, pb: PB_ONE, err: ERR_NONE};
        end else if (state_i.mode == MODE_BLK_STAR && data_i == CH_SLASH) begin
          state_o.mode = MODE_BLK_END;
        end else if (data_i == CH_STAR) begin
          state_o.mode = MODE_BLK_STAR;
        end else begin
          state_o.mode = MODE_BLK;
        end
      end
      default: begin
        state_o = ST_RESET;
      end
    endcase
  end

endmodule

### hdl/string_literal_escape_decoder.sv
// String literal escape decoder, top level: input register, decode step,
// result register. Depends on sled_pkg, sled_step and the defines header.
//
// Feed source bytes from the opening double quote onward (bytes before it are
// dropped); a zero byte marks end of file. Each decoded literal byte comes out
// as one result transaction; the literal closes with a zero byte flagged
// out_last_o, with pushback_count_o telling how many consumed source bytes
// belong to the next token, or with a nonzero error_code_o. Throughput is one
// source byte per cycle while the input side does not stall; a byte that
// yields a result passes through the input register, then the result
// register, before it is presented on the outputs. The input side stalls only
// while the held byte yields a result and the result register still holds a
// stalled one.
`include "string_literal_escape_decoder_defines.svh"

module string_literal_escape_decoder import sled_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic [1:0] pushback_count_o,
  output logic [2:0] error_code_o
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_data_q;
  state_t     state_q, state_d;
  res_t       res;
  logic       out_vld_q, out_vld_d;
  res_t       out_q;
  logic       out_free;
  logic       fire;
  logic       in_take;

  sled_step u_step (
    .state_i (state_q),
    .data_i  (in_data_q),
    .state_o (state_d),
    .res_o   (res)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && (out_free || !res.has);
  assign in_stall_o = in_vld_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire && res.has) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= ST_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_byte_i;
    end
    if (fire && res.has) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_byte_o       = out_q.data;
  assign out_last_o       = out_q.last;
  assign pushback_count_o = out_q.pb;
  assign error_code_o     = out_q.err;

  `SLED_ASSERT(a_err_shape,
    !out_valid_o || error_code_o == ERR_NONE ||
    (out_last_o && out_byte_o == 8'd0 && pushback_count_o == 2'd0),
    "error transaction not a bare terminator")
  `SLED_ASSERT(a_pb_last, !out_valid_o || pushback_count_o == 2'd0 || out_last_o,
    "pushback without last")
  `SLED_ASSERT_NEXT(a_last_resets, fire && res.has && res.last,
    state_q.mode == MODE_IDLE, "parser not idle after literal end")
  `SLED_ASSERT_NEXT(a_in_hold, in_vld_q && !fire, in_vld_q, "held source byte lost")
  `SLED_ASSERT_NEXT(a_out_hold, out_vld_q && out_stall_i, out_vld_q,
    "pending result dropped under stall")

endmodule
